>>> rtl/core/apu_pkg.sv
package apu_pkg;

    localparam int DATA_W = 32;
    localparam int CFG_W  = 24;

    // register indexes on the config port
    localparam logic [2:0] CFG_LR  = 3'd0;
    localparam logic [2:0] CFG_B1  = 3'd1;
    localparam logic [2:0] CFG_B2  = 3'd2;
    localparam logic [2:0] CFG_B1P = 3'd3;
    localparam logic [2:0] CFG_B2P = 3'd4;

    localparam logic [CFG_W-1:0] RST_LR  = 24'd16777;
    localparam logic [CFG_W-1:0] RST_B1  = 24'd15099494;
    localparam logic [CFG_W-1:0] RST_B2  = 24'd16760438;
    localparam logic [CFG_W-1:0] RST_B1P = 24'd15099494;
    localparam logic [CFG_W-1:0] RST_B2P = 24'd16760438;

    // 1.0 in Q0.24, one bit wider than a register
    localparam logic [CFG_W:0] CFG_ONE = 25'h100_0000;

    typedef struct packed {
        logic [CFG_W-1:0] lr;
        logic [CFG_W-1:0] b1;
        logic [CFG_W-1:0] b2;
        logic [CFG_W-1:0] b1p;
        logic [CFG_W-1:0] b2p;
    } t_cfg;

    typedef struct packed {
        logic signed [31:0] weight;
        logic signed [31:0] gradient;
        logic signed [31:0] first_moment;
        logic        [31:0] second_moment;
        logic               is_last;
    } t_in;

    typedef struct packed {
        logic signed [31:0] new_weight;
        logic signed [31:0] new_first_moment;
        logic        [31:0] new_second_moment;
        logic               last_out;
    } t_out;

    // word passed from front to back: weight plus the updated moments
    typedef struct packed {
        logic signed [31:0] weight;
        logic signed [31:0] first_moment;
        logic        [31:0] second_moment;
        logic               last;
    } t_mid;

endpackage

>>> rtl/core/adam_parameter_update_top.sv
// Delay from input word to output word is set by the divider and root pipelines.
// Throughput: one word per cycle; the front stalls only when its last stage
// holds a word and its 4-entry queue is full, and the back runs whenever its
// output register is free or being taken.
// Reset (synchronous, active low) empties all stages and the queue and loads
// the default learning rate and decay factors.
module adam_parameter_update_top #(
    parameter int FRAC_BITS = 24
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  logic [2:0]    i_cfg_idx,
    input  logic [23:0]   i_cfg_data,
    input  logic          i_valid,
    output logic          o_ready,
    input  apu_pkg::t_in  i_data,
    output logic          o_valid,
    input  logic          i_ready,
    output apu_pkg::t_out o_data
);

    apu_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.lr  <= apu_pkg::RST_LR;
            r_cfg.b1  <= apu_pkg::RST_B1;
            r_cfg.b2  <= apu_pkg::RST_B2;
            r_cfg.b1p <= apu_pkg::RST_B1P;
            r_cfg.b2p <= apu_pkg::RST_B2P;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                apu_pkg::CFG_LR:  r_cfg.lr  <= i_cfg_data;
                apu_pkg::CFG_B1:  r_cfg.b1  <= i_cfg_data;
                apu_pkg::CFG_B2:  r_cfg.b2  <= i_cfg_data;
                apu_pkg::CFG_B1P: r_cfg.b1p <= i_cfg_data;
                apu_pkg::CFG_B2P: r_cfg.b2p <= i_cfg_data;
                default: ;
            endcase
        end
    end

    logic          f_valid;
    apu_pkg::t_mid f_data;
    logic          q_full;
    logic          q_valid;
    apu_pkg::t_mid q_data;
    logic          q_pop;

    apu_front #(.FRAC_BITS(FRAC_BITS)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_data  (i_data),
        .o_valid (f_valid),
        .o_data  (f_data),
        .i_full  (q_full)
    );

    apu_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_valid),
        .i_data  (f_data),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_data  (q_data)
    );

    apu_back #(.FRAC_BITS(FRAC_BITS)) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (q_valid),
        .i_data  (q_data),
        .o_pop   (q_pop),
        .o_valid (o_valid),
        .o_data  (o_data),
        .i_ready (i_ready)
    );

endmodule

>>> rtl/core/apu_front.sv
module apu_front #(
    parameter int FRAC_BITS = 24
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  apu_pkg::t_cfg i_cfg,
    input  logic          i_valid,
    output logic          o_ready,
    input  apu_pkg::t_in  i_data,
    output logic          o_valid,
    output apu_pkg::t_mid o_data,
    input  logic          i_full
);

    logic en;
    logic [4:0] r_vld;

    assign en      = !r_vld[4] || !i_full;
    assign o_ready = en;
    assign o_valid = r_vld[4];

    // stage A: |g| and the moment products
    logic        [31:0] gmag;
    logic        [24:0] ob1;
    logic signed [56:0] pm1_full;
    logic signed [56:0] pm2_full;
    logic        [55:0] pv1_full;

    assign gmag     = i_data.gradient[31] ? (~i_data.gradient + 32'd1) : i_data.gradient;
    assign ob1      = apu_pkg::CFG_ONE - {1'b0, i_cfg.b1};
    assign pm1_full = $signed({1'b0, i_cfg.b1}) * i_data.first_moment;
    assign pm2_full = $signed({1'b0, ob1}) * i_data.gradient;
    assign pv1_full = i_cfg.b2 * i_data.second_moment;

    logic        [31:0] r_a_gmag;
    logic signed [56:0] r_a_pm1;
    logic signed [56:0] r_a_pm2;
    logic        [55:0] r_a_pv1;
    logic signed [31:0] r_a_w;
    logic               r_a_last;

    // stage B
    logic        [63:0] r_b_gsq;
    logic signed [56:0] r_b_msum;
    logic        [55:0] r_b_pv1;
    logic signed [31:0] r_b_w;
    logic               r_b_last;

    // stage C
    logic        [63:0] gs;
    logic signed [56:0] ms;
    logic        [32:0] mq;
    logic        [31:0] g2;
    logic signed [31:0] msat;
    logic        [31:0] r_c_g2;
    logic signed [31:0] r_c_m;
    logic        [55:0] r_c_pv1;
    logic signed [31:0] r_c_w;
    logic               r_c_last;

    assign gs   = r_b_gsq + (64'd1 << (FRAC_BITS - 1));
    assign g2   = (|(gs >> (FRAC_BITS + 32))) ? 32'hFFFF_FFFF : 32'(gs >> FRAC_BITS);
    // ties away from zero: bias down by one for negative sums
    assign ms   = r_b_msum + 57'sd8388608 - {56'd0, r_b_msum[56]};
    assign mq   = ms[56:24];
    assign msat = (mq[32] != mq[31]) ? (mq[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF)
                                     : mq[31:0];

    // stage D
    logic [24:0] ob2;
    logic [56:0] pv2_full;
    logic [56:0] r_d_pv2;
    logic [55:0] r_d_pv1;
    logic signed [31:0] r_d_m;
    logic signed [31:0] r_d_w;
    logic               r_d_last;

    assign ob2      = apu_pkg::CFG_ONE - {1'b0, i_cfg.b2};
    assign pv2_full = ob2 * r_c_g2;

    // stage E
    logic [56:0] vs;
    logic [31:0] vsat;
    apu_pkg::t_mid r_e;

    assign vs   = {1'b0, r_d_pv1} + r_d_pv2 + 57'd8388608;
    assign vsat = vs[56] ? 32'hFFFF_FFFF : vs[55:24];
    assign o_data = r_e;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[3:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a_gmag <= gmag;
            r_a_pm1  <= pm1_full;
            r_a_pm2  <= pm2_full;
            r_a_pv1  <= pv1_full;
            r_a_w    <= i_data.weight;
            r_a_last <= i_data.is_last;

            r_b_gsq  <= r_a_gmag * r_a_gmag;
            r_b_msum <= r_a_pm1 + r_a_pm2;
            r_b_pv1  <= r_a_pv1;
            r_b_w    <= r_a_w;
            r_b_last <= r_a_last;

            r_c_g2   <= g2;
            r_c_m    <= msat;
            r_c_pv1  <= r_b_pv1;
            r_c_w    <= r_b_w;
            r_c_last <= r_b_last;

            r_d_pv2  <= pv2_full;
            r_d_pv1  <= r_c_pv1;
            r_d_m    <= r_c_m;
            r_d_w    <= r_c_w;
            r_d_last <= r_c_last;

            r_e.weight        <= r_d_w;
            r_e.first_moment  <= r_d_m;
            r_e.second_moment <= vsat;
            r_e.last          <= r_d_last;
        end
    end

endmodule

>>> rtl/core/apu_fifo.sv
module apu_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  apu_pkg::t_mid i_data,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_valid,
    output apu_pkg::t_mid o_data
);

    localparam int DEPTH = 4;
    localparam int AW    = $clog2(DEPTH);

    apu_pkg::t_mid r_mem [DEPTH];
    logic [AW-1:0] r_wp;
    logic [AW-1:0] r_rp;
    logic [AW:0]   r_cnt;
    logic          do_push;
    logic          do_pop;

    assign o_full  = (r_cnt == (AW+1)'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) r_wp <= r_wp + 1'b1;
            if (do_pop)  r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + (AW+1)'(do_push) - (AW+1)'(do_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) r_mem[r_wp] <= i_data;
    end

endmodule

>>> rtl/core/apu_div.sv
// Pipelined restoring divider, one quotient bit per stage.
// o_ovf flags a quotient of 2**Q_W or more.
module apu_div #(
    parameter int NUM_W  = 57,
    parameter int DEN_W  = 25,
    parameter int Q_W    = 33,
    parameter int SIDE_W = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  logic [NUM_W-1:0]  i_num,
    input  logic [DEN_W-1:0]  i_den,
    input  logic [SIDE_W-1:0] i_side,
    output logic              o_valid,
    output logic [Q_W-1:0]    o_quo,
    output logic              o_ovf,
    output logic [SIDE_W-1:0] o_side
);

    localparam int H_W = NUM_W - Q_W;
    localparam int C_W = (H_W > DEN_W) ? H_W : DEN_W;

    logic [Q_W:0]       r_vld;
    logic [DEN_W-1:0]   r_rem  [Q_W+1];
    logic [DEN_W-1:0]   r_den  [Q_W+1];
    logic [Q_W-1:0]     r_low  [Q_W+1];
    logic [Q_W-1:0]     r_quo  [Q_W+1];
    logic               r_ovf  [Q_W+1];
    logic [SIDE_W-1:0]  r_side [Q_W+1];

    logic [C_W-1:0] hi_x;
    logic [C_W-1:0] den_x;

    assign hi_x  = C_W'(i_num[NUM_W-1:Q_W]);
    assign den_x = C_W'(i_den);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else if (i_en) begin
            r_vld[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0]  <= DEN_W'(hi_x);
            r_den[0]  <= i_den;
            r_low[0]  <= i_num[Q_W-1:0];
            r_quo[0]  <= '0;
            r_ovf[0]  <= (hi_x >= den_x);
            r_side[0] <= i_side;
        end
    end

    for (genvar k = 1; k <= Q_W; k++) begin : g_st
        logic [DEN_W:0] t;
        logic [DEN_W:0] d;
        logic           ge;

        assign t  = {r_rem[k-1], r_low[k-1][Q_W-1]};
        assign d  = {1'b0, r_den[k-1]};
        assign ge = (t >= d);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (i_en) begin
                r_vld[k] <= r_vld[k-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k]  <= ge ? DEN_W'(t - d) : DEN_W'(t);
                r_den[k]  <= r_den[k-1];
                r_low[k]  <= r_low[k-1] << 1;
                r_quo[k]  <= {r_quo[k-1][Q_W-2:0], ge};
                r_ovf[k]  <= r_ovf[k-1];
                r_side[k] <= r_side[k-1];
            end
        end
    end

    assign o_valid = r_vld[Q_W];
    assign o_quo   = r_quo[Q_W];
    assign o_ovf   = r_ovf[Q_W];
    assign o_side  = r_side[Q_W];

endmodule

>>> rtl/core/apu_sqrt.sv
// Pipelined integer square root of (i_x << SH), one root bit per stage.
module apu_sqrt #(
    parameter int IN_W   = 32,
    parameter int SH     = 24,
    parameter int SIDE_W = 8
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_valid,
    input  logic [IN_W-1:0]               i_x,
    input  logic [SIDE_W-1:0]             i_side,
    output logic                          o_valid,
    output logic [(IN_W+SH+1)/2-1:0]      o_root,
    output logic [SIDE_W-1:0]             o_side
);

    localparam int XW = IN_W + SH;
    localparam int RW = (XW + 1) / 2;
    localparam int PW = 2 * RW;

    logic [RW-1:0]     r_vld;
    logic [PW-1:0]     r_x    [RW];
    logic [RW+1:0]     r_rem  [RW];
    logic [RW-1:0]     r_root [RW];
    logic [SIDE_W-1:0] r_side [RW];

    for (genvar k = 0; k < RW; k++) begin : g_st
        logic [PW-1:0]     px;
        logic [RW+1:0]     prem;
        logic [RW-1:0]     proot;
        logic              pv;
        logic [SIDE_W-1:0] ps;
        logic [RW+3:0]     t;
        logic [RW+3:0]     trial;
        logic              ge;

        if (k == 0) begin : g_first
            assign px    = PW'(i_x) << SH;
            assign prem  = '0;
            assign proot = '0;
            assign pv    = i_valid;
            assign ps    = i_side;
        end else begin : g_next
            assign px    = r_x[k-1];
            assign prem  = r_rem[k-1];
            assign proot = r_root[k-1];
            assign pv    = r_vld[k-1];
            assign ps    = r_side[k-1];
        end

        assign t     = {prem, px[PW-1:PW-2]};
        assign trial = (RW+4)'({proot, 2'b01});
        assign ge    = (t >= trial);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (i_en) begin
                r_vld[k] <= pv;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_x[k]    <= px << 2;
                r_rem[k]  <= ge ? (RW+2)'(t - trial) : (RW+2)'(t);
                r_root[k] <= {proot[RW-2:0], ge};
                r_side[k] <= ps;
            end
        end
    end

    assign o_valid = r_vld[RW-1];
    assign o_root  = r_root[RW-1];
    assign o_side  = r_side[RW-1];

endmodule

>>> rtl/core/apu_back.sv
module apu_back #(
    parameter int FRAC_BITS = 24
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  apu_pkg::t_cfg i_cfg,
    input  logic          i_valid,
    input  apu_pkg::t_mid i_data,
    output logic          o_pop,
    output logic          o_valid,
    output apu_pkg::t_out o_data,
    input  logic          i_ready
);

    localparam int UP    = (FRAC_BITS >= 24) ? FRAC_BITS - 24 : 0;
    localparam int DN    = (FRAC_BITS < 24) ? 24 - FRAC_BITS : 0;
    localparam int RW    = (32 + FRAC_BITS + 1) / 2;
    localparam int MID_W = $bits(apu_pkg::t_mid);
    localparam int SD_W  = 32 + MID_W;
    localparam int SNUM_W = 57 + UP;
    localparam int SDEN_W = 32 + DN;
    localparam int SQ_W  = 34;

    logic          en;
    logic          r_ovld;
    apu_pkg::t_out r_out;

    assign en      = !r_ovld || i_ready;
    assign o_pop   = en && i_valid;
    assign o_valid = r_ovld;
    assign o_data  = r_out;

    // bias correction numerators, rounding folded in as +d/2
    logic [31:0] mmag;
    logic [24:0] d1;
    logic [24:0] d2;
    logic [56:0] num_m;
    logic [56:0] num_v;

    assign mmag  = i_data.first_moment[31] ? (~i_data.first_moment + 32'd1)
                                           : i_data.first_moment;
    assign d1    = apu_pkg::CFG_ONE - {1'b0, i_cfg.b1p};
    assign d2    = apu_pkg::CFG_ONE - {1'b0, i_cfg.b2p};
    assign num_m = 57'({mmag, 24'd0}) + 57'(d1 >> 1);
    assign num_v = 57'({i_data.second_moment, 24'd0}) + 57'(d2 >> 1);

    logic                     dm_valid;
    logic [32:0]              dm_quo;
    logic                     dm_ovf;
    logic                     dm_sign;
    logic                     dv_valid;
    logic [32:0]              dv_quo;
    logic                     dv_ovf;
    logic [MID_W-1:0]         dv_side;

    apu_div #(.NUM_W(57), .DEN_W(25), .Q_W(33), .SIDE_W(1)) u_div_m (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_valid),
        .i_num   (num_m),
        .i_den   (d1),
        .i_side  (i_data.first_moment[31]),
        .o_valid (dm_valid),
        .o_quo   (dm_quo),
        .o_ovf   (dm_ovf),
        .o_side  (dm_sign)
    );

    apu_div #(.NUM_W(57), .DEN_W(25), .Q_W(33), .SIDE_W(MID_W)) u_div_v (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_valid),
        .i_num   (num_v),
        .i_den   (d2),
        .i_side  (i_data),
        .o_valid (dv_valid),
        .o_quo   (dv_quo),
        .o_ovf   (dv_ovf),
        .o_side  (dv_side)
    );

    // saturate the corrected moments
    logic signed [31:0] mhat;
    logic        [31:0] vhat;
    logic               m_big;

    assign m_big = dm_ovf || (dm_quo[32:31] != 2'b00);
    assign vhat  = (dv_ovf || dv_quo[32]) ? 32'hFFFF_FFFF : dv_quo[31:0];
    always_comb begin
        if (dm_sign) begin
            mhat = m_big ? 32'sh8000_0000 : -$signed(dm_quo[31:0]);
        end else begin
            mhat = (m_big || dm_quo[31]) ? 32'sh7FFF_FFFF : $signed(dm_quo[31:0]);
        end
    end

    logic               r_b2_vld;
    logic signed [31:0] r_b2_mhat;
    logic        [31:0] r_b2_vhat;
    logic [MID_W-1:0]   r_b2_mid;

    logic               sq_valid;
    logic [RW-1:0]      sq_root;
    logic [SD_W-1:0]    sq_side;

    apu_sqrt #(.IN_W(32), .SH(FRAC_BITS), .SIDE_W(SD_W)) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_b2_vld),
        .i_x     (r_b2_vhat),
        .i_side  ({r_b2_mhat, r_b2_mid}),
        .o_valid (sq_valid),
        .o_root  (sq_root),
        .o_side  (sq_side)
    );

    // step numerator lr*|mhat| and denominator root+1 (epsilon = one lsb)
    logic signed [31:0] sq_mhat;
    logic        [31:0] hmag;

    assign sq_mhat = sq_side[SD_W-1:MID_W];
    assign hmag    = sq_mhat[31] ? (~sq_mhat + 32'd1) : sq_mhat;

    logic               r_s1_vld;
    logic        [55:0] r_s1_prod;
    logic        [31:0] r_s1_den;
    logic               r_s1_sign;
    logic [MID_W-1:0]   r_s1_mid;

    logic [SDEN_W-1:0]  sd;
    logic               r_s2_vld;
    logic [SNUM_W-1:0]  r_s2_num;
    logic [SDEN_W-1:0]  r_s2_den;
    logic [MID_W:0]     r_s2_side;

    assign sd = SDEN_W'(r_s1_den) << DN;

    logic               ds_valid;
    logic [SQ_W-1:0]    ds_quo;
    logic               ds_ovf;
    logic [MID_W:0]     ds_side;

    apu_div #(.NUM_W(SNUM_W), .DEN_W(SDEN_W), .Q_W(SQ_W), .SIDE_W(MID_W+1)) u_div_s (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_s2_vld),
        .i_num   (r_s2_num),
        .i_den   (r_s2_den),
        .i_side  (r_s2_side),
        .o_valid (ds_valid),
        .o_quo   (ds_quo),
        .o_ovf   (ds_ovf),
        .o_side  (ds_side)
    );

    // w - step, saturated; an overflowed step saturates the weight either way
    apu_pkg::t_mid      fmid;
    logic        [33:0] smag;
    logic signed [35:0] sval;
    logic signed [35:0] diff;
    logic signed [31:0] wsat;

    assign fmid = ds_side[MID_W-1:0];
    assign smag = ds_ovf ? '1 : ds_quo;
    assign sval = ds_side[MID_W] ? -$signed({2'b00, smag}) : $signed({2'b00, smag});
    assign diff = 36'(fmid.weight) - sval;
    assign wsat = (diff > 36'sd2147483647)  ? 32'sh7FFF_FFFF :
                  (diff < -36'sd2147483648) ? 32'sh8000_0000 : diff[31:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b2_vld <= 1'b0;
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
            r_ovld   <= 1'b0;
        end else if (en) begin
            r_b2_vld <= dm_valid && dv_valid;
            r_s1_vld <= sq_valid;
            r_s2_vld <= r_s1_vld;
            r_ovld   <= ds_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_b2_mhat <= mhat;
            r_b2_vhat <= vhat;
            r_b2_mid  <= dv_side;

            r_s1_prod <= i_cfg.lr * hmag;
            r_s1_den  <= 32'(sq_root) + 32'd1;
            r_s1_sign <= sq_mhat[31];
            r_s1_mid  <= sq_side[MID_W-1:0];

            r_s2_num  <= (SNUM_W'(r_s1_prod) << UP) + SNUM_W'(sd >> 1);
            r_s2_den  <= sd;
            r_s2_side <= {r_s1_sign, r_s1_mid};

            r_out.new_weight        <= wsat;
            r_out.new_first_moment  <= fmid.first_moment;
            r_out.new_second_moment <= fmid.second_moment;
            r_out.last_out          <= fmid.last;
        end
    end

endmodule

>>> rtl/core/apu_chk.sv
module apu_chk (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          o_ready,
    input logic          o_valid,
    input logic          i_ready,
    input apu_pkg::t_out o_data
);

    // a stalled output word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_data))
        else $error("output word changed while stalled");

    // reset empties the back pipeline
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid right after reset");

    // with the front empty after reset, input is taken at once
    a_rst_ready: assert property (@(posedge i_clk)
        !i_rst_n |=> o_ready)
        else $error("input not ready right after reset");

    // no word reaches the output just after reset is released
    a_no_early: assert property (@(posedge i_clk)
        !i_rst_n ##1 i_rst_n |=> !o_valid)
        else $error("output valid too soon after reset");

endmodule

bind adam_parameter_update_top apu_chk u_chk (.*);

>>> test/tb_adam_parameter_update_top.sv
`timescale 1ns / 1ps

module tb_adam_parameter_update_top;

    localparam int          FRAC        = 24;
    localparam int          DRAIN_WAIT  = 130;
    localparam logic [2:0]  CFG_IDX_MAX = 3'd7;
    localparam longint unsigned ONE     = 64'd1 << apu_pkg::CFG_W;

    logic          i_clk = 1'b0;
    logic          i_rst_n = 1'b0;
    logic          i_cfg_we = 1'b0;
    logic [2:0]    i_cfg_idx = apu_pkg::CFG_LR;
    logic [23:0]   i_cfg_data = '0;
    logic          i_valid = 1'b0;
    logic          o_ready;
    apu_pkg::t_in  i_data = '0;
    logic          o_valid;
    logic          i_ready = 1'b0;
    apu_pkg::t_out o_data;

    adam_parameter_update_top #(.FRAC_BITS(FRAC)) dut (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_idx, .i_cfg_data,
        .i_valid, .o_ready, .i_data, .o_valid, .i_ready, .o_data
    );

    // our copy of the optimizer settings
    longint unsigned lr_r, b1_r, b2_r, b1p_r, b2p_r;

    apu_pkg::t_in  pending_words[$];
    apu_pkg::t_out expected_updates[$];
    int   fail_cnt = 0;
    int   burst_left = 1;
    int   gap_left = 0;
    int   rx_mode = 0;
    int   rx_left = 0;

    initial forever #1 i_clk = ~i_clk;

    function automatic longint unsigned div_rnd_u(longint unsigned n, longint unsigned d);
        return (n + d / 2) / d;
    endfunction

    function automatic longint div_rnd_s(longint n, longint unsigned d);
        longint unsigned mag;
        if (n < 0) begin
            mag = longint'(-n);
            return -longint'(div_rnd_u(mag, d));
        end
        return longint'(div_rnd_u(longint'(n), d));
    endfunction

    function automatic longint clip_s32(longint x);
        if (x > 64'sd2147483647) return 64'sd2147483647;
        if (x < -64'sd2147483648) return -64'sd2147483648;
        return x;
    endfunction

    function automatic longint unsigned clip_u32(longint unsigned x);
        return (x > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : x;
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned x);
        longint unsigned res, bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > x) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (x >= res + bitv) begin
                x = x - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    function automatic apu_pkg::t_out adam_step(apu_pkg::t_in x);
        longint          w, g, m, m_new, m_hat, num, stepv;
        longint unsigned v, gmag, g_sq, v_new, v_hat, den;
        apu_pkg::t_out   r;
        w = longint'(x.weight);
        g = longint'(x.gradient);
        m = longint'(x.first_moment);
        v = 64'(x.second_moment);
        gmag = (g < 0) ? longint'(-g) : longint'(g);
        g_sq = clip_u32(div_rnd_u(gmag * gmag, 64'd1 << FRAC));
        m_new = clip_s32(div_rnd_s(longint'(b1_r) * m + longint'(ONE - b1_r) * g, ONE));
        v_new = clip_u32(div_rnd_u(b2_r * v + (ONE - b2_r) * g_sq, ONE));
        m_hat = clip_s32(div_rnd_s(m_new * longint'(ONE), ONE - b1p_r));
        v_hat = clip_u32(div_rnd_u(v_new << apu_pkg::CFG_W, ONE - b2p_r));
        den = int_sqrt(v_hat << FRAC) + 1;
        num = longint'(lr_r) * m_hat;
        stepv = div_rnd_s(num, den);
        r.new_weight = 32'(clip_s32(w - stepv));
        r.new_first_moment = 32'(m_new);
        r.new_second_moment = 32'(v_new);
        r.last_out = x.is_last;
        return r;
    endfunction

    // sender: bursts with random gaps
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && o_ready) expected_updates = {expected_updates, adam_step(i_data)};
            if (!i_valid || o_ready) begin
                if (gap_left > 0) begin
                    gap_left <= gap_left - 1;
                    i_valid <= 1'b0;
                end else if (pending_words.size() > 0) begin
                    i_data <= pending_words.pop_front();
                    i_valid <= 1'b1;
                    if (burst_left <= 1) begin
                        burst_left <= $urandom_range(1, 40);
                        gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9);
                    end else begin
                        burst_left <= burst_left - 1;
                    end
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // receiver: random stall pattern, switching between modes
    always @(posedge i_clk) begin
        if (rx_left == 0) begin
            rx_mode <= $urandom_range(0, 2);
            rx_left <= $urandom_range(10, 80);
        end else begin
            rx_left <= rx_left - 1;
        end
        case (rx_mode)
            0: i_ready <= 1'b1;
            1: i_ready <= 1'($urandom_range(0, 1));
            default: i_ready <= ($urandom_range(0, 3) == 0);
        endcase
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_updates.size() == 0) begin
                $error("unexpected word: new_weight %0d", o_data.new_weight);
                fail_cnt++;
            end else begin
                apu_pkg::t_out e;
                e = expected_updates.pop_front();
                if (o_data.new_weight !== e.new_weight) begin
                    $error("new_weight: expected %0d, got %0d", e.new_weight, o_data.new_weight);
                    fail_cnt++;
                end
                if (o_data.new_first_moment !== e.new_first_moment) begin
                    $error("new_first_moment: expected %0d, got %0d",
                           e.new_first_moment, o_data.new_first_moment);
                    fail_cnt++;
                end
                if (o_data.new_second_moment !== e.new_second_moment) begin
                    $error("new_second_moment: expected %0d, got %0d",
                           e.new_second_moment, o_data.new_second_moment);
                    fail_cnt++;
                end
                if (o_data.last_out !== e.last_out) begin
                    $error("last_out: expected %0d, got %0d", e.last_out, o_data.last_out);
                    fail_cnt++;
                end
            end
        end
    end

    task automatic write_reg(logic [2:0] idx, logic [23:0] val);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        case (idx)
            apu_pkg::CFG_LR:  lr_r = 64'(val);
            apu_pkg::CFG_B1:  b1_r = 64'(val);
            apu_pkg::CFG_B2:  b2_r = 64'(val);
            apu_pkg::CFG_B1P: b1p_r = 64'(val);
            apu_pkg::CFG_B2P: b2p_r = 64'(val);
            default: ;
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic write_all(logic [23:0] lr, logic [23:0] b1, logic [23:0] b2,
                             logic [23:0] b1p, logic [23:0] b2p);
        write_reg(apu_pkg::CFG_LR, lr);
        write_reg(apu_pkg::CFG_B1, b1);
        write_reg(apu_pkg::CFG_B2, b2);
        write_reg(apu_pkg::CFG_B1P, b1p);
        write_reg(apu_pkg::CFG_B2P, b2p);
    endtask

    task automatic wait_drained();
        do @(posedge i_clk);
        while (pending_words.size() != 0 || expected_updates.size() != 0 || i_valid);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    task automatic add_word(logic [31:0] w, logic [31:0] g, logic [31:0] m,
                            logic [31:0] v, logic l);
        apu_pkg::t_in x;
        x.weight = w;
        x.gradient = g;
        x.first_moment = m;
        x.second_moment = v;
        x.is_last = l;
        pending_words = {pending_words, x};
    endtask

    function automatic logic [31:0] near_zero(int span);
        int s;
        s = $urandom_range(0, span);
        return ($urandom_range(0, 1) == 1) ? 32'(s) : 32'(-s);
    endfunction

    task automatic push_random(int n);
        for (int k = 0; k < n; k++) begin
            if ($urandom_range(0, 9) < 6)
                add_word(near_zero(1 << 26), near_zero(1 << 24), near_zero(1 << 22),
                         $urandom_range(0, 1 << 20), $urandom_range(0, 7) == 0);
            else
                add_word($urandom, $urandom, $urandom, $urandom, 1'($urandom_range(0, 1)));
        end
    endtask

    initial begin
        lr_r = 64'(apu_pkg::RST_LR);
        b1_r = 64'(apu_pkg::RST_B1);
        b2_r = 64'(apu_pkg::RST_B2);
        b1p_r = 64'(apu_pkg::RST_B1P);
        b2p_r = 64'(apu_pkg::RST_B2P);
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings, directed corners first
        add_word(32'h0, 32'h0, 32'h0, 32'h0, 1'b0);
        add_word(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b1);
        add_word(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'hFFFF_FFFF, 1'b0);
        add_word(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h0, 1'b1);
        add_word(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0, 1'b0);
        add_word(32'h0100_0000, 32'h0000_0001, 32'h0, 32'h0, 1'b0);     // zero second moment
        add_word(32'h0100_0000, 32'hFFFF_FFFF, 32'h0, 32'h0, 1'b1);
        add_word(32'hFF00_0000, 32'h0100_0000, 32'h0100_0000, 32'h0100_0000, 1'b0);
        add_word(32'h0, 32'h0000_1000, 32'h0000_0800, 32'h0000_0010, 1'b1);
        add_word(32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 1'b0);
        add_word(32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 1'b1);
        add_word(32'h0, 32'h1000_0000, 32'h0, 32'h8000_0000, 1'b0);
        push_random(90);
        wait_drained();

        // all factors zero
        write_all(24'h0, 24'h0, 24'h0, 24'h0, 24'h0);
        add_word(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b1);
        push_random(90);
        wait_drained();

        // all factors at full scale: bias divisors are one lsb
        write_all(24'hFF_FFFF, 24'hFF_FFFF, 24'hFF_FFFF, 24'hFF_FFFF, 24'hFF_FFFF);
        add_word(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 1'b0);
        push_random(90);
        wait_drained();

        // large step, typical decays, early step count
        write_all(24'hFF_FFFF, 24'd15099494, 24'd16760438, 24'd15099494, 24'd16760438);
        push_random(100);
        wait_drained();

        // unused indexes must leave settings alone
        write_all(24'($urandom), 24'($urandom), 24'($urandom), 24'($urandom),
                  24'($urandom));
        for (int idx = apu_pkg::CFG_B2P + 1; idx <= CFG_IDX_MAX; idx++)
            write_reg(3'(idx), 24'($urandom));
        push_random(100);
        wait_drained();

        if (fail_cnt == 0)
            $display("tb_adam_parameter_update_top: PASS");
        else
            $display("tb_adam_parameter_update_top: FAIL");
        $finish;
    end

    initial begin
        #400000;
        $display("tb_adam_parameter_update_top: FAIL");
        $finish;
    end

endmodule
